@@ rtl/hcd_pkg.sv @@
// Shared types, constants and filter taps for the Harris corner detector.
package hcd_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int MIN_SIZE    = 13;
  localparam int MARGIN      = 6;        // half window, judged pixel offset
  localparam int POS_W       = 10;       // row / col field width
  localparam int FRAC        = 16;       // Q0.16
  localparam int THRESH_STEP = 2000000;

  localparam int PIX_W  = 8;
  localparam int GRAD_W = 12;
  localparam int XX_W   = 20;
  localparam int XY_W   = 21;
  localparam int ENT_W  = 2 * XX_W + XY_W;   // one stored (xx, xy, yy) triple
  localparam int NLINE  = 10;                // stored product lines
  localparam int NTAP   = 9;                 // nonzero Gaussian taps
  localparam int NHALF  = 5;
  localparam int TAP_W  = 22;                // signed smoothed value
  localparam int HLEN   = 10;                // horizontal shift line
  localparam int NSTAGE = 13;

  // symmetric Q0.16 taps, outermost first, center last
  localparam logic [15:0] GAUSS [NHALF] = '{16'd9, 16'd290, 16'd3538, 16'd15858, 16'd26145};

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_THRESH = 2'd2,
    CFG_K      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             valid;
    logic             emit;
    logic             frame_end;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } ctl_t;

endpackage

@@ rtl/hcd_front.sv @@
// Pixel line memory, 3x3 window, Sobel, gradient products and product line memory.
module hcd_front import hcd_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic                    acc_i,
  input  logic [PIX_W-1:0]        pixel_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] slot_i,
  input  logic                    v1_i,
  input  logic                    v4_i,
  output logic signed [TAP_W-1:0] vxx_o [NTAP],
  output logic signed [TAP_W-1:0] vxy_o [NTAP],
  output logic signed [TAP_W-1:0] vyy_o [NTAP]
);

  localparam int SW = $clog2(MAX_WIDTH);
  localparam int LW = NLINE * ENT_W;

  logic [2*PIX_W-1:0] pix_mem [MAX_WIDTH];
  logic [LW-1:0]      prod_mem [MAX_WIDTH];

  logic [2*PIX_W-1:0] pix_rd_q;
  logic [PIX_W-1:0]   px1_q;
  logic [SW-1:0]      slot1_q, slot2_q, slot3_q, slot4_q;
  logic [LW-1:0]      prd1_q, prd2_q, prd3_q, prd4_q;
  logic [PIX_W-1:0]   win_q [3][3];
  logic signed [GRAD_W-1:0] ix_q, iy_q;
  logic signed [GRAD_W-1:0] ix_d, iy_d;
  logic signed [2*GRAD_W-1:0] xx_full, xy_full, yy_full;
  logic [XX_W-1:0]    xx_q, yy_q;
  logic [XY_W-1:0]    xy_q;

  // both line memories read on accept; pixel lines shift-write one stage later
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      pix_rd_q <= pix_mem[slot_i];
      prd1_q   <= prod_mem[slot_i];
      px1_q    <= pixel_i;
      slot1_q  <= slot_i;
    end
    if (en_i && v1_i) begin
      pix_mem[slot1_q] <= {pix_rd_q[PIX_W-1:0], px1_q};
    end
    if (en_i && v4_i) begin
      prod_mem[slot4_q] <= {prd4_q[(NLINE-1)*ENT_W-1:0], yy_q, xy_q, xx_q};
    end
  end

  // window, row 0 = two lines up, column 2 = newest
  always_ff @(posedge clk_i) begin
    if (en_i && v1_i) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= pix_rd_q[2*PIX_W-1:PIX_W];
      win_q[1][2] <= pix_rd_q[PIX_W-1:0];
      win_q[2][2] <= px1_q;
    end
  end

  always_comb begin
    ix_d = (GRAD_W'(win_q[0][2]) + (GRAD_W'(win_q[1][2]) << 1) + GRAD_W'(win_q[2][2]))
         - (GRAD_W'(win_q[0][0]) + (GRAD_W'(win_q[1][0]) << 1) + GRAD_W'(win_q[2][0]));
    iy_d = (GRAD_W'(win_q[2][0]) + (GRAD_W'(win_q[2][1]) << 1) + GRAD_W'(win_q[2][2]))
         - (GRAD_W'(win_q[0][0]) + (GRAD_W'(win_q[0][1]) << 1) + GRAD_W'(win_q[0][2]));
  end

  assign xx_full = ix_q * ix_q;
  assign xy_full = ix_q * iy_q;
  assign yy_full = iy_q * iy_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ix_q    <= ix_d;
      iy_q    <= iy_d;
      xx_q    <= xx_full[XX_W-1:0];
      xy_q    <= xy_full[XY_W-1:0];
      yy_q    <= yy_full[XX_W-1:0];
      prd2_q  <= prd1_q;
      prd3_q  <= prd2_q;
      prd4_q  <= prd3_q;
      slot2_q <= slot1_q;
      slot3_q <= slot2_q;
      slot4_q <= slot3_q;
    end
  end

  // vertical taps: stored lines 1..9 carry the nonzero weights
  always_comb begin
    for (int k = 0; k < NTAP; k++) begin
      vxx_o[k] = TAP_W'(prd1_q[(k+1)*ENT_W +: XX_W]);
      vxy_o[k] = TAP_W'($signed(prd1_q[(k+1)*ENT_W + XX_W +: XY_W]));
      vyy_o[k] = TAP_W'(prd1_q[(k+1)*ENT_W + XX_W + XY_W +: XX_W]);
    end
  end

endmodule

@@ rtl/hcd_gauss.sv @@
// Nine-tap symmetric Gaussian: pre-add, constant multiply, sum and round.
module hcd_gauss import hcd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [TAP_W-1:0] tap_i [NTAP],
  output logic signed [TAP_W-1:0] res_o
);

  localparam int MW = TAP_W + 18;
  localparam int SW = MW + 3;

  logic signed [TAP_W:0]   pre_q [NHALF];
  logic signed [MW-1:0]    mul_q [NHALF];
  logic signed [SW-1:0]    sum_d, rnd_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NHALF - 1; k++) begin
        pre_q[k] <= (TAP_W+1)'(tap_i[k]) + (TAP_W+1)'(tap_i[NTAP-1-k]);
      end
      pre_q[NHALF-1] <= (TAP_W+1)'(tap_i[NHALF-1]);
      for (int k = 0; k < NHALF; k++) begin
        mul_q[k] <= MW'(pre_q[k]) * MW'($signed({1'b0, GAUSS[k]}));
      end
      res_o <= rnd_d[TAP_W-1:0];
    end
  end

  // round half up: arithmetic shift of x + 0.5
  always_comb begin
    sum_d = SW'(1 << (FRAC - 1));
    for (int k = 0; k < NHALF; k++) begin
      sum_d = sum_d + SW'(mul_q[k]);
    end
    rnd_d = sum_d >>> FRAC;
  end

endmodule

@@ rtl/hcd_resp.sv @@
// Harris response det - k*trace^2 and threshold compare, five stages.
module hcd_resp import hcd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [TAP_W-1:0] a_i,
  input  logic signed [TAP_W-1:0] b_i,
  input  logic signed [TAP_W-1:0] c_i,
  input  logic [15:0]             k_i,
  input  logic [7:0]              thr_i,
  output logic                    hit_o
);

  localparam int PW = 2 * TAP_W;
  localparam int TW = TAP_W + 1;
  localparam int T2 = 2 * TW;
  localparam int HB = T2 / 2;
  localparam int KW = 64;
  localparam int CW = 66;

  logic signed [PW-1:0]   ac_q, bb_q;
  logic signed [TW-1:0]   tr_q;
  logic signed [PW:0]     det_q;
  logic signed [T2-1:0]   tr2_q;
  logic signed [KW-1:0]   det16_q, det16b_q;
  logic [HB+15:0]         plo_q;
  logic [T2-HB+15:0]      phi_q;
  logic [31:0]            rhs_q, rhsb_q;
  logic [KW-1:0]          ktr_q;
  logic signed [CW-1:0]   lhs_d, lim_d;

  assign lhs_d = CW'(det16b_q) - $signed({2'b00, ktr_q});
  assign lim_d = $signed({18'd0, rhsb_q, 16'd0});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_q     <= PW'(a_i) * PW'(c_i);
      bb_q     <= PW'(b_i) * PW'(b_i);
      tr_q     <= TW'(a_i) + TW'(c_i);
      det_q    <= (PW+1)'(ac_q) - (PW+1)'(bb_q);
      tr2_q    <= T2'(tr_q) * T2'(tr_q);
      det16_q  <= KW'(det_q) <<< FRAC;
      plo_q    <= (HB+16)'(tr2_q[HB-1:0]) * (HB+16)'(k_i);
      phi_q    <= (T2-HB+16)'(tr2_q[T2-1:HB]) * (T2-HB+16)'(k_i);
      rhs_q    <= 32'(thr_i) * 32'(THRESH_STEP);
      det16b_q <= det16_q;
      rhsb_q   <= rhs_q;
      ktr_q    <= KW'(plo_q) + (KW'(phi_q) << HB);
      hit_o    <= lhs_d > lim_d;
    end
  end

endmodule

@@ rtl/harris_corner_detector_unit.sv @@
// Harris corner detector top: 8-bit raster pixels in, one corner verdict per interior pixel.
// A pixel's verdict (if any) leaves the last pipeline stage through the output register onto m_axis.
// Throughput: one pixel per cycle; the pipeline halts only while a second verdict
// would collide with one the sink has not taken.
// Reset clears the counters, the stage valid bits, the horizontal shift line and the output
// valid, loads register defaults; line memories are not cleared and hold garbage until written.
module harris_corner_detector_unit import hcd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] pixel
  input  logic        s_axis_tuser_i,   // [0] frame_start
  // verdict stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [9:0] row, [19:10] col, [23:20] zero
  output logic        m_axis_tuser_o,   // [0] is_corner
  output logic        m_axis_tlast_o,   // frame_end
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // configuration
  logic [10:0] fw_q, fh_q;
  logic [7:0]  thr_q;
  logic [15:0] k_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= 11'd640;
      fh_q  <= 11'd480;
      thr_q <= 8'd30;
      k_q   <= 16'd3277;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  fw_q  <= cfg_data_i[10:0];
        CFG_HEIGHT: fh_q  <= cfg_data_i[10:0];
        CFG_THRESH: thr_q <= cfg_data_i[7:0];
        CFG_K:      k_q   <= cfg_data_i;
      endcase
    end
  end

  // effective frame size, clamped into [13, MAX]
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (32'(fw_q) < MIN_SIZE)       w_eff = WW'(MIN_SIZE);
    else if (32'(fw_q) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else                            w_eff = WW'(fw_q);
    if (32'(fh_q) < MIN_SIZE)        h_eff = HW'(MIN_SIZE);
    else if (32'(fh_q) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else                             h_eff = HW'(fh_q);
  end

  // flow control: stall only when a verdict leaves the last stage into a full output
  ctl_t ctl_q [NSTAGE];
  logic last_emit, stall, en, acc;

  assign last_emit       = ctl_q[NSTAGE-1].valid && ctl_q[NSTAGE-1].emit;
  assign stall           = last_emit && m_axis_tvalid_o && !m_axis_tready_i;
  assign en              = !stall;
  assign acc             = s_axis_tvalid_i && en;
  assign s_axis_tready_o = en;

  // position counters of the incoming pixel
  logic [RW-1:0] row_q, row_d, r_cur;
  logic [CW-1:0] col_q, col_d, c_cur;
  ctl_t          ctl_new;

  always_comb begin
    r_cur = s_axis_tuser_i ? '0 : row_q;
    c_cur = s_axis_tuser_i ? '0 : col_q;
    if (32'(c_cur) + 1 >= 32'(w_eff)) begin
      col_d = '0;
      row_d = (32'(r_cur) + 1 >= 32'(h_eff)) ? '0 : r_cur + RW'(1);
    end else begin
      col_d = c_cur + CW'(1);
      row_d = r_cur;
    end
    // judged pixel sits MARGIN up and left; its whole window must be inside
    ctl_new.valid     = 1'b1;
    ctl_new.emit      = 32'(r_cur) >= 2 * MARGIN && 32'(c_cur) >= 2 * MARGIN
                     && 32'(r_cur) < 32'(h_eff) && 32'(c_cur) < 32'(w_eff);
    ctl_new.frame_end = 32'(r_cur) == 32'(h_eff) - 1 && 32'(c_cur) == 32'(w_eff) - 1;
    ctl_new.row       = POS_W'(r_cur) - POS_W'(MARGIN);
    ctl_new.col       = POS_W'(c_cur) - POS_W'(MARGIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      for (int i = 0; i < NSTAGE; i++) ctl_q[i] <= '0;
    end else if (en) begin
      if (acc) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      ctl_q[0] <= acc ? ctl_new : '0;
      for (int i = 1; i < NSTAGE; i++) ctl_q[i] <= ctl_q[i-1];
    end
  end

  // stages 1..4: line memories, window, Sobel, products
  logic signed [TAP_W-1:0] vxx_tap [NTAP];
  logic signed [TAP_W-1:0] vxy_tap [NTAP];
  logic signed [TAP_W-1:0] vyy_tap [NTAP];

  hcd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .acc_i   (acc),
    .pixel_i (s_axis_tdata_i),
    .slot_i  (c_cur),
    .v1_i    (ctl_q[0].valid),
    .v4_i    (ctl_q[3].valid),
    .vxx_o   (vxx_tap),
    .vxy_o   (vxy_tap),
    .vyy_o   (vyy_tap)
  );

  // stages 2..4: vertical smoothing of the stored product lines
  logic signed [TAP_W-1:0] vxx, vxy, vyy;

  hcd_gauss u_vxx (.clk_i(clk_i), .en_i(en), .tap_i(vxx_tap), .res_o(vxx));
  hcd_gauss u_vxy (.clk_i(clk_i), .en_i(en), .tap_i(vxy_tap), .res_o(vxy));
  hcd_gauss u_vyy (.clk_i(clk_i), .en_i(en), .tap_i(vyy_tap), .res_o(vyy));

  // horizontal shift line, index HLEN-1 newest; it moves once per real pixel
  logic signed [TAP_W-1:0] hxx_q [HLEN];
  logic signed [TAP_W-1:0] hxy_q [HLEN];
  logic signed [TAP_W-1:0] hyy_q [HLEN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < HLEN; j++) begin
        hxx_q[j] <= '0;
        hxy_q[j] <= '0;
        hyy_q[j] <= '0;
      end
    end else if (en && ctl_q[3].valid) begin
      for (int j = 0; j < HLEN - 1; j++) begin
        hxx_q[j] <= hxx_q[j+1];
        hxy_q[j] <= hxy_q[j+1];
        hyy_q[j] <= hyy_q[j+1];
      end
      hxx_q[HLEN-1] <= vxx;
      hxy_q[HLEN-1] <= vxy;
      hyy_q[HLEN-1] <= vyy;
    end
  end

  // the newest entry carries a zero weight
  logic signed [TAP_W-1:0] hxx_tap [NTAP];
  logic signed [TAP_W-1:0] hxy_tap [NTAP];
  logic signed [TAP_W-1:0] hyy_tap [NTAP];

  always_comb begin
    for (int k = 0; k < NTAP; k++) begin
      hxx_tap[k] = hxx_q[k];
      hxy_tap[k] = hxy_q[k];
      hyy_tap[k] = hyy_q[k];
    end
  end

  // stages 6..8: horizontal smoothing -> A, B, C
  logic signed [TAP_W-1:0] sa, sb, sc;

  hcd_gauss u_hxx (.clk_i(clk_i), .en_i(en), .tap_i(hxx_tap), .res_o(sa));
  hcd_gauss u_hxy (.clk_i(clk_i), .en_i(en), .tap_i(hxy_tap), .res_o(sb));
  hcd_gauss u_hyy (.clk_i(clk_i), .en_i(en), .tap_i(hyy_tap), .res_o(sc));

  // stages 9..13: response and threshold
  logic hit;

  hcd_resp u_resp (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (sa),
    .b_i   (sb),
    .c_i   (sc),
    .k_i   (k_q),
    .thr_i (thr_q),
    .hit_o (hit)
  );

  // output register, decouples the sink from the pipeline
  logic             out_valid_q;
  logic             corner_q, fend_q;
  logic [POS_W-1:0] orow_q, ocol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && last_emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && last_emit) begin
      corner_q <= hit;
      fend_q   <= ctl_q[NSTAGE-1].frame_end;
      orow_q   <= ctl_q[NSTAGE-1].row;
      ocol_q   <= ctl_q[NSTAGE-1].col;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, ocol_q, orow_q};
  assign m_axis_tuser_o  = corner_q;
  assign m_axis_tlast_o  = fend_q;

endmodule
